FILE: rtl/svpq_pkg.sv
// Package with the transaction types, operation codes and defaults of the voice priority queue.
`timescale 1ns / 1ps

package svpq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_RETIRE = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] priority_req;
    logic [15:0]        voice_handle;
  } req_t;

  typedef struct packed {
    logic        evicted_valid;
    logic [15:0] evicted_handle;
    logic [4:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic signed [15:0] prio;
    logic [15:0]        handle;
  } entry_t;

endpackage

FILE: rtl/sound_voice_priority_queue_unit.sv
// Top level of the voice priority queue: request sequencer, entry memory and response register.
//
//   Channel | Direction | Handshake            | Payload
//   req     | in        | req_valid, req_stall | req (req_t)
//   rsp     | out       | rsp_valid, rsp_stall | rsp (rsp_t)
//
// One request is worked at a time; each entry walked takes a memory read and
// then the compare and write back on the registered read data.
// Retire walks every entry in the list; clear and unused codes walk none.
// Reset empties the list at once; the memory holds no reset value and needs no clearing pass.
// A stalled response is held in its register while the next request is taken and worked.
`timescale 1ns / 1ps

module sound_voice_priority_queue_unit import svpq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int AW = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_EV   = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  typedef enum logic [2:0] {
    M_BACK   = 3'b001,
    M_FWD    = 3'b010,
    M_RETIRE = 3'b100
  } mode_t;

  state_t        state, state_next;
  mode_t         mode, mode_next;
  logic [CW-1:0] k, k_next;
  logic [CW-1:0] w, w_next;
  logic [CW-1:0] fill, fill_next;
  req_t          cur, cur_next;
  logic          ev_valid, ev_valid_next;
  logic [15:0]   ev_handle, ev_handle_next;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, mem_rdata;
  entry_t        new_entry;
  logic [CW-1:0] k_dec;
  logic [CW+4:0] count_wide;

  assign new_entry  = '{prio: cur.priority_req, handle: cur.voice_handle};
  assign k_dec      = k - CW'(1);
  assign count_wide = {5'd0, fill};
  assign req_stall  = (state != S_IDLE);

  svpq_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_comb begin
    state_next     = state;
    mode_next      = mode;
    k_next         = k;
    w_next         = w;
    fill_next      = fill;
    cur_next       = cur;
    ev_valid_next  = ev_valid;
    ev_handle_next = ev_handle;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = new_entry;
    mem_re         = 1'b0;
    mem_raddr      = '0;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cur_next       = req;
          ev_valid_next  = 1'b0;
          ev_handle_next = '0;
          k_next         = '0;
          w_next         = '0;
          state_next     = S_DONE;
          case (req.operation)
            OP_ADD: begin
              state_next = S_RD;
              if (fill == CW'(QUEUE_DEPTH)) begin
                mode_next     = M_FWD;
                ev_valid_next = 1'b1;
              end else begin
                mode_next = M_BACK;
                k_next    = fill;
              end
            end
            OP_RETIRE: begin
              mode_next  = M_RETIRE;
              state_next = S_RD;
            end
            OP_CLEAR: begin
              fill_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        unique case (mode)
          M_BACK: begin
            if (k == '0) begin
              mem_we     = 1'b1;
              mem_waddr  = '0;
              fill_next  = fill + CW'(1);
              state_next = S_DONE;
            end else begin
              mem_re     = 1'b1;
              mem_raddr  = k_dec[AW-1:0];
              state_next = S_EV;
            end
          end
          M_FWD: begin
            if (k == CW'(QUEUE_DEPTH)) begin
              mem_we     = 1'b1;
              mem_waddr  = k_dec[AW-1:0];
              state_next = S_DONE;
            end else begin
              mem_re     = 1'b1;
              mem_raddr  = k[AW-1:0];
              state_next = S_EV;
            end
          end
          M_RETIRE: begin
            if (k == fill) begin
              fill_next  = w;
              state_next = S_DONE;
            end else begin
              mem_re     = 1'b1;
              mem_raddr  = k[AW-1:0];
              state_next = S_EV;
            end
          end
        endcase
      end
      S_EV: begin
        state_next = S_RD;
        unique case (mode)
          M_BACK: begin
            mem_we    = 1'b1;
            mem_waddr = k[AW-1:0];
            if (mem_rdata.prio > cur.priority_req) begin
              mem_wdata = mem_rdata;
              k_next    = k_dec;
            end else begin
              fill_next  = fill + CW'(1);
              state_next = S_DONE;
            end
          end
          M_FWD: begin
            if (k == '0) begin
              ev_handle_next = mem_rdata.handle;
              k_next         = CW'(1);
            end else begin
              mem_we    = 1'b1;
              mem_waddr = k_dec[AW-1:0];
              if (mem_rdata.prio <= cur.priority_req) begin
                mem_wdata = mem_rdata;
                k_next    = k + CW'(1);
              end else begin
                state_next = S_DONE;
              end
            end
          end
          M_RETIRE: begin
            k_next = k + CW'(1);
            if (mem_rdata.handle != cur.voice_handle) begin
              mem_we    = 1'b1;
              mem_waddr = w[AW-1:0];
              mem_wdata = mem_rdata;
              w_next    = w + CW'(1);
            end
          end
        endcase
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mode      <= M_BACK;
      fill      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      mode  <= mode_next;
      fill  <= fill_next;
      if (state == S_DONE && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    k         <= k_next;
    w         <= w_next;
    cur       <= cur_next;
    ev_valid  <= ev_valid_next;
    ev_handle <= ev_handle_next;
    if (state == S_DONE && (!rsp_valid || !rsp_stall)) begin
      rsp.evicted_valid  <= ev_valid;
      rsp.evicted_handle <= ev_handle;
      rsp.entry_count    <= count_wide[4:0];
    end
  end

endmodule

FILE: rtl/svpq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module svpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
